### design/tbi_pkg.sv
// ----------------------------------------------------------------------------
// tbi_pkg: shared types and constants for the tiered backoff interval block
// Holds the configuration record, the item passed from the front end to the
// back end, opcode and register index codes, and the limit and default constants.
// ----------------------------------------------------------------------------
package tbi_pkg;

    localparam int unsigned POS_W      = 32;
    localparam int unsigned MS_W       = 24;
    localparam int unsigned RATIO_W    = 17;
    localparam int unsigned UNIT_W     = 16;
    localparam int unsigned FAIL_W     = 16;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam int unsigned QDEPTH     = 2;
    localparam int unsigned QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [FAIL_W-1:0]  FAIL_MAX          = 16'hFFFF;
    localparam logic [FAIL_W-1:0]  BACKOFF_AFTER_DEF = 16'd3;
    localparam logic [RATIO_W-1:0] RATIO_ONE         = 17'h10000;
    localparam logic [4:0]         SHIFT_LIMIT       = 5'd25;

    localparam logic [OP_W-1:0] OP_NONE    = 2'd0;
    localparam logic [OP_W-1:0] OP_SUCCESS = 2'd1;
    localparam logic [OP_W-1:0] OP_FAILURE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR_POS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_POS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_MS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_MS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_MS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_MS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER_RAT  = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0]   near_pos_limit;
        logic [POS_W-1:0]   far_pos_limit;
        logic [MS_W-1:0]    near_interval_ms;
        logic [MS_W-1:0]    middle_interval_ms;
        logic [MS_W-1:0]    far_interval_ms;
        logic [MS_W-1:0]    floor_interval_ms;
        logic [MS_W-1:0]    cap_interval_ms;
        logic [RATIO_W-1:0] jitter_ratio_q16;
    } t_cfg;

    typedef struct packed {
        logic [MS_W-1:0]   base_ms;
        logic [FAIL_W-1:0] failure_count;
        logic              backoff_active;
        logic [UNIT_W-1:0] jitter_unit_q16;
    } t_item;

endpackage

### design/tbi_cfg_regs.sv
// ----------------------------------------------------------------------------
// tbi_cfg_regs: configuration register file
// Eight write-only registers, written through a plain enable/index/data port.
// ----------------------------------------------------------------------------
module tbi_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [tbi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tbi_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output tbi_pkg::t_cfg                     o_cfg
);

    tbi_pkg::t_cfg r_cfg;
    tbi_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tbi_pkg::REG_NEAR_POS:   n_cfg.near_pos_limit     = i_cfg_wdata;
                tbi_pkg::REG_FAR_POS:    n_cfg.far_pos_limit      = i_cfg_wdata;
                tbi_pkg::REG_NEAR_MS:    n_cfg.near_interval_ms   = i_cfg_wdata[23:0];
                tbi_pkg::REG_MIDDLE_MS:  n_cfg.middle_interval_ms = i_cfg_wdata[23:0];
                tbi_pkg::REG_FAR_MS:     n_cfg.far_interval_ms    = i_cfg_wdata[23:0];
                tbi_pkg::REG_FLOOR_MS:   n_cfg.floor_interval_ms  = i_cfg_wdata[23:0];
                tbi_pkg::REG_CAP_MS:     n_cfg.cap_interval_ms    = i_cfg_wdata[23:0];
                tbi_pkg::REG_JITTER_RAT: n_cfg.jitter_ratio_q16   = i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_pos_limit     <= 32'd10;
            r_cfg.far_pos_limit      <= 32'd1000;
            r_cfg.near_interval_ms   <= 24'd1000;
            r_cfg.middle_interval_ms <= 24'd5000;
            r_cfg.far_interval_ms    <= 24'd30000;
            r_cfg.floor_interval_ms  <= 24'd500;
            r_cfg.cap_interval_ms    <= 24'd60000;
            r_cfg.jitter_ratio_q16   <= 17'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/tbi_front.sv
// ----------------------------------------------------------------------------
// tbi_front: transaction intake, failure counting and tier selection
// Records the outcome, picks the tier base and queues the classified item.
// ----------------------------------------------------------------------------
module tbi_front #(
    parameter logic [15:0] BACKOFF_AFTER = tbi_pkg::BACKOFF_AFTER_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tbi_pkg::t_cfg                  i_cfg,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [tbi_pkg::OP_W-1:0]       i_opcode,
    input  logic [tbi_pkg::POS_W-1:0]      i_queue_position,
    input  logic [tbi_pkg::UNIT_W-1:0]     i_jitter_unit_q16,
    output logic                           o_item_valid,
    output tbi_pkg::t_item                 o_item,
    input  logic                           i_item_take
);

    logic [tbi_pkg::FAIL_W-1:0]  r_fail;
    logic [tbi_pkg::FAIL_W-1:0]  n_fail;
    tbi_pkg::t_item              r_q [tbi_pkg::QDEPTH];
    logic [tbi_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [tbi_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [tbi_pkg::QCNT_W-1:0]  r_count;
    logic                        accept;
    logic                        take;
    tbi_pkg::t_item              new_item;
    logic [tbi_pkg::MS_W-1:0]    tier_ms;

    assign o_full       = (r_count == tbi_pkg::QCNT_W'(tbi_pkg::QDEPTH));
    assign accept       = i_push && !o_full;
    assign o_item_valid = (r_count != '0);
    assign take         = i_item_take && o_item_valid;

    always_comb begin
        unique case (i_opcode)
            tbi_pkg::OP_SUCCESS: n_fail = '0;
            tbi_pkg::OP_FAILURE: n_fail = (r_fail == tbi_pkg::FAIL_MAX) ? r_fail
                                                                        : r_fail + 1'b1;
            default:             n_fail = r_fail;
        endcase
    end

    always_comb begin
        if (i_queue_position > i_cfg.far_pos_limit) begin
            tier_ms = i_cfg.far_interval_ms;
        end else if (i_queue_position <= i_cfg.near_pos_limit) begin
            tier_ms = i_cfg.near_interval_ms;
        end else begin
            tier_ms = i_cfg.middle_interval_ms;
        end
    end

    always_comb begin
        new_item.base_ms         = tier_ms;
        new_item.failure_count   = n_fail;
        new_item.backoff_active  = (n_fail >= BACKOFF_AFTER);
        new_item.jitter_unit_q16 = i_jitter_unit_q16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail   <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_fail   <= n_fail;
                r_wr_ptr <= (r_wr_ptr == tbi_pkg::QPTR_W'(tbi_pkg::QDEPTH - 1)) ? '0
                                                                             : r_wr_ptr + 1'b1;
            end
            if (take) begin
                r_rd_ptr <= (r_rd_ptr == tbi_pkg::QPTR_W'(tbi_pkg::QDEPTH - 1)) ? '0
                                                                             : r_rd_ptr + 1'b1;
            end
            if (accept && !take) begin
                r_count <= r_count + 1'b1;
            end else if (take && !accept) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= new_item;
        end
    end

    assign o_item = r_q[r_rd_ptr];

endmodule

### design/tbi_back.sv
// ----------------------------------------------------------------------------
// tbi_back: backoff, jitter scaling and clamp
// A small sequencer that doubles the base, scales it by the jitter factor
// through split multiplies, clamps it and holds the result for the receiver.
// ----------------------------------------------------------------------------
module tbi_back #(
    parameter logic [15:0] BACKOFF_AFTER = tbi_pkg::BACKOFF_AFTER_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tbi_pkg::t_cfg                  i_cfg,
    input  logic                           i_item_valid,
    input  tbi_pkg::t_item                 i_item,
    output logic                           o_item_take,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [tbi_pkg::MS_W-1:0]       o_interval_ms,
    output logic [tbi_pkg::FAIL_W-1:0]     o_failure_count,
    output logic                           o_backoff_active
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_BACKOFF = 3'd1;
    localparam logic [2:0] ST_SCALE   = 3'd2;
    localparam logic [2:0] ST_MUL     = 3'd3;
    localparam logic [2:0] ST_SUM     = 3'd4;

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    tbi_pkg::t_item              r_item;
    logic [tbi_pkg::MS_W-1:0]    r_base;
    logic [32:0]                 r_ru;
    logic [33:0]                 r_scale;
    logic [40:0]                 r_plo;
    logic [40:0]                 r_phi;
    logic                        r_out_valid;
    logic [tbi_pkg::MS_W-1:0]    r_out_ms;
    logic [tbi_pkg::FAIL_W-1:0]  r_out_fail;
    logic                        r_out_act;

    logic [16:0]                 shift_n;
    logic [47:0]                 shifted;
    logic [tbi_pkg::MS_W-1:0]    backoff_ms;
    logic [tbi_pkg::RATIO_W-1:0] ratio;
    logic [57:0]                 product;
    logic [25:0]                 jittered;
    logic [tbi_pkg::MS_W-1:0]    clamped;
    logic                        out_free;

    assign out_free    = !r_out_valid || i_pop;
    assign o_item_take = (r_state == ST_IDLE);

    always_comb begin
        shift_n = {1'b0, r_item.failure_count} - {1'b0, BACKOFF_AFTER} + 17'd1;
        shifted = {24'd0, r_item.base_ms} << shift_n[4:0];
        if (!r_item.backoff_active || r_item.base_ms >= i_cfg.cap_interval_ms
            || r_item.base_ms == '0) begin
            backoff_ms = r_item.base_ms;
        end else if (shift_n >= {12'd0, tbi_pkg::SHIFT_LIMIT}) begin
            backoff_ms = i_cfg.cap_interval_ms;
        end else if (shifted > {24'd0, i_cfg.cap_interval_ms}) begin
            backoff_ms = i_cfg.cap_interval_ms;
        end else begin
            backoff_ms = shifted[23:0];
        end
    end

    assign ratio = (i_cfg.jitter_ratio_q16 > tbi_pkg::RATIO_ONE) ? tbi_pkg::RATIO_ONE
                                                                 : i_cfg.jitter_ratio_q16;

    always_comb begin
        product  = {r_phi, 17'd0} + {17'd0, r_plo};
        jittered = product[57:32];
        if (jittered < {2'd0, i_cfg.floor_interval_ms}) begin
            clamped = i_cfg.floor_interval_ms;
        end else if (jittered > {2'd0, i_cfg.cap_interval_ms}) begin
            clamped = i_cfg.cap_interval_ms;
        end else begin
            clamped = jittered[23:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_item_valid) n_state = ST_BACKOFF;
            ST_BACKOFF: n_state = ST_SCALE;
            ST_SCALE:   n_state = ST_MUL;
            ST_MUL:     n_state = ST_SUM;
            ST_SUM:     if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SUM && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_item_valid) begin
            r_item <= i_item;
        end
        if (r_state == ST_BACKOFF) begin
            r_base <= backoff_ms;
            r_ru   <= ratio * r_item.jitter_unit_q16;
        end
        if (r_state == ST_SCALE) begin
            r_scale <= 34'h1_0000_0000 - {1'b0, ratio, 16'd0} + {r_ru, 1'b0};
        end
        if (r_state == ST_MUL) begin
            r_plo <= r_base * r_scale[16:0];
            r_phi <= r_base * r_scale[33:17];
        end
        if (r_state == ST_SUM && out_free) begin
            r_out_ms   <= clamped;
            r_out_fail <= r_item.failure_count;
            r_out_act  <= r_item.backoff_active;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_interval_ms    = r_out_ms;
    assign o_failure_count  = r_out_fail;
    assign o_backoff_active = r_out_act;

endmodule

### design/tiered_backoff_interval_top.sv
// ----------------------------------------------------------------------------
// tiered_backoff_interval_top: poll interval generator with backoff and jitter
// Each transaction records a poll outcome and returns the next poll interval.
//
// Input channel: a transaction is taken when i_push is high and o_full is
// low. The outcome updates the failure count at once and the item waits in
// a two-entry queue for the back end.
// Result channel: while o_empty is low the oldest result is on the output
// ports; it is taken when i_pop is high.
// The back end works on one item at a time through capture, backoff, scale,
// split multiply, sum and clamp, and takes the next item only after the
// last result has been placed in the output register.
// Configuration writes go through i_cfg_wr_en, i_cfg_index and i_cfg_wdata
// and take effect at the next edge; the user must make them only while the
// block is idle, and the block itself does not enforce this. Reset empties
// both queues, clears the failure count and loads the register defaults.
// When the receiver stalls the result is held, the back end waits and the
// input queue fills until o_full rises.
// ----------------------------------------------------------------------------
module tiered_backoff_interval_top #(
    parameter logic [15:0] BACKOFF_AFTER = tbi_pkg::BACKOFF_AFTER_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tbi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tbi_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [tbi_pkg::OP_W-1:0]       i_opcode,
    input  logic [tbi_pkg::POS_W-1:0]      i_queue_position,
    input  logic [tbi_pkg::UNIT_W-1:0]     i_jitter_unit_q16,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [tbi_pkg::MS_W-1:0]       o_interval_ms,
    output logic [tbi_pkg::FAIL_W-1:0]     o_failure_count,
    output logic                           o_backoff_active
);

    tbi_pkg::t_cfg  cfg;
    tbi_pkg::t_item item;
    logic           item_valid;
    logic           item_take;

    tbi_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tbi_front #(
        .BACKOFF_AFTER (BACKOFF_AFTER)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_opcode          (i_opcode),
        .i_queue_position  (i_queue_position),
        .i_jitter_unit_q16 (i_jitter_unit_q16),
        .o_item_valid      (item_valid),
        .o_item            (item),
        .i_item_take       (item_take)
    );

    tbi_back #(
        .BACKOFF_AFTER (BACKOFF_AFTER)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_item_valid     (item_valid),
        .i_item           (item),
        .o_item_take      (item_take),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_interval_ms    (o_interval_ms),
        .o_failure_count  (o_failure_count),
        .o_backoff_active (o_backoff_active)
    );

endmodule

### design/tbi_checker.sv
// ----------------------------------------------------------------------------
// tbi_port_checks: port-level checks for the tiered backoff interval block
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
module tbi_port_checks #(
    parameter logic [15:0] BACKOFF_AFTER = tbi_pkg::BACKOFF_AFTER_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_full,
    input logic                           o_empty,
    input logic                           i_pop,
    input logic [tbi_pkg::MS_W-1:0]       o_interval_ms,
    input logic [tbi_pkg::FAIL_W-1:0]     o_failure_count,
    input logic                           o_backoff_active
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty && !o_full)
        else $error("result queue not empty or input full after reset");

    a_active_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_backoff_active == (o_failure_count >= BACKOFF_AFTER)))
        else $error("backoff flag disagrees with failure count");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_interval_ms)
                               && $stable(o_failure_count))
        else $error("stalled result changed");

    a_fail_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && i_pop ##1 !o_empty && $past(o_failure_count) != 16'hFFFF
        |-> o_failure_count <= $past(o_failure_count) + 17'd1)
        else $error("failure count rose by more than one between results");

endmodule

bind tiered_backoff_interval_top tbi_port_checks #(
    .BACKOFF_AFTER (BACKOFF_AFTER)
) u_tbi_port_checks (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_full           (o_full),
    .o_empty          (o_empty),
    .i_pop            (i_pop),
    .o_interval_ms    (o_interval_ms),
    .o_failure_count  (o_failure_count),
    .o_backoff_active (o_backoff_active)
);

### tb/tbi_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tbi_checker: result checker for the tiered backoff interval block
// Watches the configuration port and both transaction channels, keeps its
// own copy of the registers and the failure count, works out the expected
// interval for every accepted input transaction and compares each accepted
// result with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module tbi_checker
    import tbi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_push,
    input  logic                  o_full,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [POS_W-1:0]      i_queue_position,
    input  logic [UNIT_W-1:0]     i_jitter_unit_q16,
    input  logic                  o_empty,
    input  logic                  i_pop,
    input  logic [MS_W-1:0]       o_interval_ms,
    input  logic [FAIL_W-1:0]     o_failure_count,
    input  logic                  o_backoff_active,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [MS_W-1:0]   interval_ms;
        logic [FAIL_W-1:0] failure_count;
        logic              backoff_active;
    } t_poll_result;

    t_cfg              regs;
    logic [FAIL_W-1:0] fail_run;
    t_poll_result      expected_polls[$];
    t_poll_result      want;
    int                errors = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t tbi_checker: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [MS_W-1:0] tier_base(input logic [POS_W-1:0] pos);
        if (pos > regs.far_pos_limit) return regs.far_interval_ms;
        if (pos <= regs.near_pos_limit) return regs.near_interval_ms;
        return regs.middle_interval_ms;
    endfunction

    function automatic logic [MS_W-1:0] backed_off(input logic [MS_W-1:0] base,
                                                   input logic [FAIL_W-1:0] count);
        logic [FAIL_W:0] steps;
        logic [63:0]     grown;
        if (count < BACKOFF_AFTER_DEF) return base;
        if (base >= regs.cap_interval_ms || base == '0) return base;
        steps = {1'b0, count} - {1'b0, BACKOFF_AFTER_DEF} + 1'b1;
        if (steps >= SHIFT_LIMIT) return regs.cap_interval_ms;
        grown = 64'(base) << steps;
        if (grown > 64'(regs.cap_interval_ms)) return regs.cap_interval_ms;
        return grown[MS_W-1:0];
    endfunction

    function automatic logic [63:0] jittered(input logic [MS_W-1:0] base,
                                             input logic [UNIT_W-1:0] unit);
        logic [63:0] ratio;
        logic [63:0] scale;
        ratio = 64'(regs.jitter_ratio_q16);
        if (ratio == 0) return 64'(base);
        if (ratio > 64'(RATIO_ONE)) ratio = 64'(RATIO_ONE);
        scale = (64'd1 << 32) - (ratio << 16) + 64'd2 * ratio * 64'(unit);
        return (64'(base) * scale) >> 32;
    endfunction

    function automatic t_poll_result predict_poll(input logic [POS_W-1:0] pos,
                                                  input logic [UNIT_W-1:0] unit);
        t_poll_result res;
        logic [63:0]  value;
        value = jittered(backed_off(tier_base(pos), fail_run), unit);
        if (value < 64'(regs.floor_interval_ms)) begin
            res.interval_ms = regs.floor_interval_ms;
        end else if (value > 64'(regs.cap_interval_ms)) begin
            res.interval_ms = regs.cap_interval_ms;
        end else begin
            res.interval_ms = value[MS_W-1:0];
        end
        res.failure_count  = fail_run;
        res.backoff_active = (fail_run >= BACKOFF_AFTER_DEF);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.near_pos_limit     = 32'd10;
            regs.far_pos_limit      = 32'd1000;
            regs.near_interval_ms   = 24'd1000;
            regs.middle_interval_ms = 24'd5000;
            regs.far_interval_ms    = 24'd30000;
            regs.floor_interval_ms  = 24'd500;
            regs.cap_interval_ms    = 24'd60000;
            regs.jitter_ratio_q16   = '0;
            fail_run                = '0;
            expected_polls.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_NEAR_POS:   regs.near_pos_limit     = i_cfg_wdata;
                    REG_FAR_POS:    regs.far_pos_limit      = i_cfg_wdata;
                    REG_NEAR_MS:    regs.near_interval_ms   = i_cfg_wdata[MS_W-1:0];
                    REG_MIDDLE_MS:  regs.middle_interval_ms = i_cfg_wdata[MS_W-1:0];
                    REG_FAR_MS:     regs.far_interval_ms    = i_cfg_wdata[MS_W-1:0];
                    REG_FLOOR_MS:   regs.floor_interval_ms  = i_cfg_wdata[MS_W-1:0];
                    REG_CAP_MS:     regs.cap_interval_ms    = i_cfg_wdata[MS_W-1:0];
                    REG_JITTER_RAT: regs.jitter_ratio_q16   = i_cfg_wdata[RATIO_W-1:0];
                    default: ;
                endcase
            end
            if (i_pop && !o_empty) begin
                if (expected_polls.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = expected_polls.pop_front();
                    if (o_interval_ms !== want.interval_ms) begin
                        report_mismatch($sformatf("interval_ms got %0d want %0d",
                                                  o_interval_ms, want.interval_ms));
                    end
                    if (o_failure_count !== want.failure_count) begin
                        report_mismatch($sformatf("failure_count got %0d want %0d",
                                                  o_failure_count, want.failure_count));
                    end
                    if (o_backoff_active !== want.backoff_active) begin
                        report_mismatch($sformatf("backoff_active got %0b want %0b",
                                                  o_backoff_active, want.backoff_active));
                    end
                end
            end
            if (i_push && !o_full) begin
                if (i_opcode == OP_SUCCESS) begin
                    fail_run = '0;
                end else if (i_opcode == OP_FAILURE && fail_run != FAIL_MAX) begin
                    fail_run = fail_run + 1'b1;
                end
                expected_polls.push_back(predict_poll(i_queue_position, i_jitter_unit_q16));
            end
        end
        o_errors  = errors;
        o_pending = expected_polls.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the tiered backoff interval block
// Drives a short directed sequence over the tiers, the backoff and jitter
// corner cases, a long failure run past the shift limit, then random phases
// with fresh register settings, with random gaps on both channels. The
// checker beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_top;
    import tbi_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 2;
    localparam int SETTLE_CYCLES  = 12;
    localparam int CYCLE_LIMIT    = 200_000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 240;
    localparam int FAIL_RUN_ITEMS = 40;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_push;
    logic                  o_full;
    logic [OP_W-1:0]       i_opcode;
    logic [POS_W-1:0]      i_queue_position;
    logic [UNIT_W-1:0]     i_jitter_unit_q16;
    logic                  o_empty;
    logic                  i_pop;
    logic [MS_W-1:0]       o_interval_ms;
    logic [FAIL_W-1:0]     o_failure_count;
    logic                  o_backoff_active;

    int   fail_total;
    int   pending;
    int   cycle_count = 0;
    bit   tx_quiet    = 1'b0;
    bit   rx_quiet    = 1'b0;
    bit   hold_quiet  = 1'b0;

    logic [POS_W-1:0] near_set = 32'd10;
    logic [POS_W-1:0] far_set  = 32'd1000;

    tiered_backoff_interval_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_opcode          (i_opcode),
        .i_queue_position  (i_queue_position),
        .i_jitter_unit_q16 (i_jitter_unit_q16),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_interval_ms     (o_interval_ms),
        .o_failure_count   (o_failure_count),
        .o_backoff_active  (o_backoff_active)
    );

    tbi_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_opcode          (i_opcode),
        .i_queue_position  (i_queue_position),
        .i_jitter_unit_q16 (i_jitter_unit_q16),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_interval_ms     (o_interval_ms),
        .o_failure_count   (o_failure_count),
        .o_backoff_active  (o_backoff_active),
        .o_errors          (fail_total),
        .o_pending         (pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin : result_drain
        int unsigned gap;
        i_pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
            gap = (rx_quiet || hold_quiet) ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                @(negedge i_clk);
                i_pop <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
        end
    end

    task automatic send_poll(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [UNIT_W-1:0] unit);
        int unsigned gap;
        gap = (tx_quiet || hold_quiet) ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            @(negedge i_clk);
            i_push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_push            <= 1'b1;
        i_opcode          <= op;
        i_queue_position  <= pos;
        i_jitter_unit_q16 <= unit;
        do @(posedge i_clk); while (o_full);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_NEAR_POS) near_set = data;
        if (idx == REG_FAR_POS) far_set = data;
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_ms();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'hFF_FFFF;
            2, 3:    return $urandom_range(1, 2000);
            4, 5:    return $urandom_range(1, 100000);
            default: return $urandom_range(0, 32'hFF_FFFF);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(0, 7))
            0:       return near_set;
            1:       return near_set + 1'b1;
            2:       return far_set;
            3:       return far_set + 1'b1;
            4:       return '0;
            5:       return 32'hFFFF_FFFF;
            6:       return $urandom_range(0, 2000);
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int unsigned streak;
        int unsigned pick;
        logic [OP_W-1:0] op;

        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_wdata       = '0;
        i_push            = 1'b0;
        i_opcode          = OP_NONE;
        i_queue_position  = '0;
        i_jitter_unit_q16 = '0;
        streak            = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: tier boundaries, doubling below the cap, unused opcode.
        send_poll(OP_NONE, 32'd0, 16'h0000);
        send_poll(OP_SUCCESS, 32'd10, 16'hFFFF);
        send_poll(OP_NONE, 32'd11, 16'h8000);
        send_poll(OP_NONE, 32'd1000, 16'h0000);
        send_poll(OP_NONE, 32'd1001, 16'h0000);
        send_poll(OP_FAILURE, 32'hFFFF_FFFF, 16'h0000);
        send_poll(OP_FAILURE, 32'd5, 16'h0000);
        send_poll(OP_FAILURE, 32'd5, 16'hFFFF);
        send_poll(OP_FAILURE, 32'd2000, 16'h0000);
        send_poll(OP_UNUSED, 32'd500, 16'h1234);
        send_poll(OP_SUCCESS, 32'd0, 16'h0000);

        // Overlapping tiers, zero base, base at the cap, ratio beyond one.
        settle();
        write_reg(REG_NEAR_POS, 32'hFFFF_FFFF);
        write_reg(REG_FAR_POS, 32'd0);
        write_reg(REG_NEAR_MS, 32'd0);
        write_reg(REG_MIDDLE_MS, 32'd1);
        write_reg(REG_FAR_MS, 32'hFF_FFFF);
        write_reg(REG_FLOOR_MS, 32'd0);
        write_reg(REG_CAP_MS, 32'hFF_FFFF);
        write_reg(REG_JITTER_RAT, 32'h1_FFFF);
        send_poll(OP_FAILURE, 32'd0, 16'hFFFF);
        send_poll(OP_FAILURE, 32'd1, 16'h0000);
        send_poll(OP_FAILURE, 32'd1, 16'hFFFF);
        send_poll(OP_NONE, 32'd0, 16'h0000);

        // Floor above the cap, base above the cap, full jitter ratio.
        settle();
        write_reg(REG_NEAR_POS, 32'd100);
        write_reg(REG_FAR_POS, 32'd200);
        write_reg(REG_NEAR_MS, 32'd3);
        write_reg(REG_FAR_MS, 32'd500);
        write_reg(REG_FLOOR_MS, 32'd1000);
        write_reg(REG_CAP_MS, 32'd100);
        write_reg(REG_JITTER_RAT, 32'h1_0000);
        send_poll(OP_FAILURE, 32'd300, 16'h8000);
        send_poll(OP_FAILURE, 32'd50, 16'hFFFF);
        send_poll(OP_NONE, 32'd150, 16'h0000);

        // A long failure run pushes the doubling past its shift limit.
        settle();
        write_reg(REG_FLOOR_MS, 32'd0);
        write_reg(REG_CAP_MS, 32'h80_0000);
        write_reg(REG_JITTER_RAT, 32'd40000);
        hold_quiet = 1'b1;
        send_poll(OP_SUCCESS, 32'd0, 16'h0000);
        repeat (FAIL_RUN_ITEMS) send_poll(OP_FAILURE, pick_position(), 16'($urandom));
        send_poll(OP_NONE, 32'd150, 16'hFFFF);
        send_poll(OP_SUCCESS, 32'd0, 16'h0000);
        hold_quiet = 1'b0;

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case ($urandom_range(0, 4))
                0: begin
                    write_reg(REG_NEAR_POS, 32'd0);
                    write_reg(REG_FAR_POS, $urandom_range(1, 50));
                end
                1: begin
                    write_reg(REG_NEAR_POS, $urandom_range(0, 100));
                    write_reg(REG_FAR_POS, near_set + $urandom_range(0, 500));
                end
                2: begin
                    write_reg(REG_NEAR_POS, $urandom);
                    write_reg(REG_FAR_POS, $urandom);
                end
                3: begin
                    write_reg(REG_NEAR_POS, 32'hFFFF_FFFF);
                    write_reg(REG_FAR_POS, $urandom_range(0, 10));
                end
                default: begin
                    write_reg(REG_NEAR_POS, $urandom_range(0, 20));
                    write_reg(REG_FAR_POS, 32'hFFFF_FFFF);
                end
            endcase
            write_reg(REG_NEAR_MS, rand_ms());
            write_reg(REG_MIDDLE_MS, rand_ms());
            write_reg(REG_FAR_MS, rand_ms());
            write_reg(REG_FLOOR_MS, ($urandom_range(0, 3) == 0) ? rand_ms()
                                                                : $urandom_range(0, 500));
            write_reg(REG_CAP_MS, ($urandom_range(0, 3) == 0) ? rand_ms()
                                                              : $urandom_range(50000, 32'hFF_FFFF));
            case ($urandom_range(0, 5))
                0:       write_reg(REG_JITTER_RAT, 32'd0);
                1:       write_reg(REG_JITTER_RAT, 32'h1_0000);
                2:       write_reg(REG_JITTER_RAT, $urandom_range(32'h1_0001, 32'h1_FFFF));
                default: write_reg(REG_JITTER_RAT, $urandom_range(0, 32'h1_0000));
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
                if ($urandom_range(0, 149) == 0) settle();
                if (streak != 0) begin
                    op = OP_FAILURE;
                    streak--;
                end else begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0) begin
                        streak = $urandom_range(5, 40);
                        op     = OP_FAILURE;
                    end else if (pick <= 8) begin
                        op = OP_FAILURE;
                    end else if (pick <= 12) begin
                        op = OP_SUCCESS;
                    end else if (pick <= 16) begin
                        op = OP_NONE;
                    end else begin
                        op = OP_UNUSED;
                    end
                end
                send_poll(op, pick_position(), 16'($urandom));
            end
        end

        settle();
        if (fail_total == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
